>>> rtl/core/tks_pkg.sv
// Shared types, sizes and the name clipping function for the score table.
`timescale 1ns / 1ps
`default_nettype none

package tks_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int NAME_CHARS    = 8;

  localparam int SCORE_W = 31;
  localparam int NAME_W  = 64;
  localparam int TIME_W  = 32;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [NAME_W-1:0]  name;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  // keep the low NAME_CHARS bytes up to the first zero byte
  function automatic logic [NAME_W-1:0] clip_name(input logic [NAME_W-1:0] tag);
    logic [NAME_W-1:0] kept;
    logic              alive;
    kept  = '0;
    alive = 1'b1;
    for (int k = 0; k < NAME_CHARS; k++) begin
      if (tag[8*k +: 8] == 8'd0) alive = 1'b0;
      if (alive) kept[8*k +: 8] = tag[8*k +: 8];
    end
    return kept;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tks_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tks_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/top_k_score_insertion.sv
// Top level: sorted best-score table with record and read items.
//
// Input channel (in_valid/in_ready): mode 0 records in_score with its name
// tag and time stamp, mode 1 reads the entry at in_read_index. Output channel
// (out_valid/out_ready): one result item per input item, in order.
// The table sits in a RAM with one read and one write port. A record walks
// the table from the last valid entry upward, one entry per cycle, moving
// each lower-scoring entry down one slot until it finds the insertion point.
// An ignored record goes straight to its result; a read or a drop on a full
// table first reads the RAM; an insertion into an empty table writes the
// entry directly; any other insertion walks the valid entries, and that
// walk over the single RAM read port sets how fast items are taken.
// One item is in work at a time; in_ready is high while the block is idle.
// A finished result sits in the output register; the next item is accepted
// meanwhile and its result waits until the register is taken.
// Reset clears the entry count and best score; RAM contents are not cleared,
// entries past the count are never used. A stalled receiver holds the
// result stable and stops further results, not acceptance of one more item.
`timescale 1ns / 1ps
`default_nettype none

module top_k_score_insertion (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_score,
  input  wire logic [63:0] in_name_tag,
  input  wire logic [31:0] in_time_stamp,
  input  wire logic [3:0]  in_read_index,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_accepted,
  output logic [3:0]       out_insert_rank,
  output logic [4:0]       out_entry_count,
  output logic [30:0]      out_best_score,
  output logic             out_read_valid,
  output logic [30:0]      out_read_score,
  output logic [63:0]      out_read_name,
  output logic [31:0]      out_read_time
);

  localparam int N     = tks_pkg::TABLE_ENTRIES;
  localparam int IDX_W = tks_pkg::IDX_W;
  localparam int CNT_W = tks_pkg::CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FULLCHK, S_SHIFT, S_PUT, S_RDATA, S_DONE
  } state_t;

  state_t                      state_r;
  logic [tks_pkg::SCORE_W-1:0] raw_r;
  logic [tks_pkg::NAME_W-1:0]  name_r;
  logic [tks_pkg::TIME_W-1:0]  time_r;
  logic [IDX_W-1:0]            j_r;
  logic                        acc_r;
  logic [IDX_W-1:0]            rank_r;
  logic                        rvalid_r;
  tks_pkg::entry_t             rd_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [tks_pkg::SCORE_W-1:0] best_r;

  logic                        out_valid_r;
  logic                        out_accepted_r;
  logic [IDX_W-1:0]            out_rank_r;
  logic [CNT_W-1:0]            out_cnt_r;
  logic [tks_pkg::SCORE_W-1:0] out_best_r;
  logic                        out_rvalid_r;
  tks_pkg::entry_t             out_rd_r;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  tks_pkg::entry_t             ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  tks_pkg::entry_t             ram_rdata;

  logic                        in_fire;
  logic                        in_pos;
  logic                        ridx_ok;
  logic                        full;
  logic [tks_pkg::NAME_W-1:0]  in_clip;
  logic [IDX_W-1:0]            cnt_idx;
  logic [IDX_W-1:0]            jm1;
  logic                        older_ge;
  logic                        out_free;
  tks_pkg::entry_t             new_entry;
  tks_pkg::entry_t             in_entry;
  logic [31:0]                 rank32;
  logic [31:0]                 cnt32;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_pos    = !in_score[31] && (in_score != 32'd0);
  assign ridx_ok   = 32'(in_read_index) < 32'(cnt_r);
  assign full      = 32'(cnt_r) == N;
  assign in_clip   = tks_pkg::clip_name(in_name_tag);
  assign cnt_idx   = cnt_r[IDX_W-1:0];
  assign jm1       = j_r - IDX_W'(1);
  assign older_ge  = ram_rdata.score >= raw_r;
  assign out_free  = !out_valid_r || out_ready;
  assign new_entry = '{score: raw_r, name: name_r, stamp: time_r};
  assign in_entry  = '{score: in_score[30:0], name: in_clip, stamp: in_time_stamp};

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = new_entry;
    ram_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_mode) begin
            ram_raddr = IDX_W'(in_read_index);
          end else if (in_pos && full) begin
            ram_raddr = LAST_IDX;
          end else if (in_pos && cnt_r == '0) begin
            ram_we    = 1'b1;
            ram_wdata = in_entry;
          end else begin
            ram_raddr = cnt_idx - IDX_W'(1);
          end
        end
      end
      S_FULLCHK: begin
        if (!older_ge) begin
          if (j_r == '0) ram_we = 1'b1;
          else ram_raddr = jm1;
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        if (!older_ge) begin
          ram_wdata = ram_rdata;
          ram_raddr = jm1 - IDX_W'(1);
        end
      end
      S_PUT: begin
        ram_we = 1'b1;
      end
      S_RDATA, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  tks_ram #(
    .DEPTH (N),
    .WIDTH ($bits(tks_pkg::entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            raw_r    <= in_score[30:0];
            name_r   <= in_clip;
            time_r   <= in_time_stamp;
            acc_r    <= 1'b0;
            rank_r   <= '0;
            rvalid_r <= 1'b0;
            rd_r     <= '0;
            if (in_mode) begin
              state_r <= ridx_ok ? S_RDATA : S_DONE;
            end else if (!in_pos) begin
              state_r <= S_DONE;
            end else if (full) begin
              j_r     <= LAST_IDX;
              state_r <= S_FULLCHK;
            end else if (cnt_r == '0) begin
              acc_r   <= 1'b1;
              state_r <= S_DONE;
            end else begin
              j_r     <= cnt_idx;
              state_r <= S_SHIFT;
            end
          end
        end
        S_FULLCHK: begin
          if (older_ge) begin
            state_r <= S_DONE;
          end else if (j_r == '0) begin
            acc_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (older_ge) begin
            acc_r   <= 1'b1;
            rank_r  <= j_r;
            state_r <= S_DONE;
          end else begin
            j_r <= jm1;
            if (jm1 == '0) state_r <= S_PUT;
          end
        end
        S_PUT: begin
          acc_r   <= 1'b1;
          state_r <= S_DONE;
        end
        S_RDATA: begin
          rvalid_r <= 1'b1;
          rd_r     <= ram_rdata;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_accepted_r <= acc_r;
            out_rank_r     <= rank_r;
            out_rvalid_r   <= rvalid_r;
            out_rd_r       <= rd_r;
            if (acc_r && !full) begin
              cnt_r     <= cnt_r + CNT_W'(1);
              out_cnt_r <= cnt_r + CNT_W'(1);
            end else begin
              out_cnt_r <= cnt_r;
            end
            if (acc_r && rank_r == '0) begin
              best_r     <= raw_r;
              out_best_r <= raw_r;
            end else begin
              out_best_r <= best_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rank32          = 32'(out_rank_r);
  assign cnt32           = 32'(out_cnt_r);
  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_insert_rank = rank32[3:0];
  assign out_entry_count = cnt32[4:0];
  assign out_best_score  = out_best_r;
  assign out_read_valid  = out_rvalid_r;
  assign out_read_score  = out_rd_r.score;
  assign out_read_name   = out_rd_r.name;
  assign out_read_time   = out_rd_r.stamp;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= N)
    else $error("entry count above table size");

  a_no_write_idle_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDATA || state_r == S_DONE) |-> !ram_we)
    else $error("table written during read or result phase");

  a_acc_xor_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_accepted_r && out_rvalid_r))
    else $error("result both inserted and read");

  a_acc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_accepted_r) |-> (out_cnt_r != '0 && out_best_r != '0))
    else $error("insertion left table empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DONE) |=> $stable(cnt_r))
    else $error("entry count changed outside result phase");

endmodule

`default_nettype wire
